// ===== src/rpd_pkg.sv =====
// Package with the shared types and constants of the radius point dedup block.
package rpd_pkg;

  // Field widths of one point and of one result.
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned RADIUS_W  = 23;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned DIST_W    = SQ_W + 2;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned IN_DATA_W  = 3 * COORD_W;
  localparam int unsigned OUT_DATA_W = 24;

  // Verdict codes.
  localparam logic [VERDICT_W-1:0] VERDICT_KEPT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DUP  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_FULL = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RAD  = 8'b0000_0010,
    S_READ = 8'b0000_0100,
    S_X    = 8'b0000_1000,
    S_Y    = 8'b0001_0000,
    S_Z    = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

// ===== src/rpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rpd_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/radius_point_dedup.sv =====
// Top level of the radius point dedup block: sequencer, shared multiplier and point table.
//
// Each input point is compared with the kept points one at a time and is dropped as a
// duplicate when its squared distance to any of them is strictly below the squared
// radius; otherwise it is appended to the table, or dropped as full when no slot is
// left. A point with start_of_set in tuser empties the table first. One result leaves
// per point. An item scans the kept entries (all of them, or up to and including the
// first one within the radius), and its result is held back while the output register
// still waits for m_tready. The scan runs on the single 24x24 multiplier, which squares
// the radius once and then the x, y and z differences of each entry in turn, fed by one
// table read port. The block is not ready for a new point while one is in work. The
// table needs no clearing after reset, since only entries below the kept count are
// ever read.
module radius_point_dedup #(
  parameter int unsigned MAX_KEPT = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Point stream.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [rpd_pkg::IN_DATA_W-1:0]        s_tdata,  // point_x, point_y, point_z
  input  logic                                 s_tuser,  // start_of_set
  // Result stream.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [rpd_pkg::OUT_DATA_W-1:0]       m_tdata,  // verdict, slot_index, kept_count
  // Radius register write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rpd_pkg::RADIUS_W-1:0]         cfg_data   // dup_radius
);

  import rpd_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_KEPT);
  localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);

  state_t state;

  logic [RADIUS_W-1:0] dup_radius;
  logic [COORD_W-1:0]  px;
  logic [COORD_W-1:0]  py;
  logic [COORD_W-1:0]  pz;
  logic [CNT_W-1:0]    total;
  logic [ADDR_W-1:0]   idx;
  logic                dup;
  logic [SQ_W-1:0]     r2;
  logic [SQ_W-1:0]     sq;
  logic [DIST_W-1:0]   acc;

  logic [IN_DATA_W-1:0] rd_data;
  logic                 ram_we;
  logic                 ram_re;

  logic [COORD_W-1:0]  pt_coord;
  logic [COORD_W-1:0]  kept_coord;
  logic [COORD_W:0]    diff;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    mul_op;
  logic [SQ_W-1:0]     mul_out;
  logic [DIST_W-1:0]   dist_sum;
  logic                near;
  logic [CNT_W-1:0]    idx_inc;
  logic                out_free;
  logic                load_out;
  logic [VERDICT_W-1:0] verdict_next;
  logic [CNT_W-1:0]    total_after;
  logic [CNT_W-1:0]    slot_cnt;
  logic [CNT_W+8:0]    slot_ext;
  logic [CNT_W+8:0]    count_ext;

  // The radius register is always ready; the user must write it only while idle, as the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dup_radius <= RADIUS_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      dup_radius <= cfg_data;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == S_OUT) && out_free;

  // Axis select for the shared difference and multiplier.
  always_comb begin
    case (state)
      S_X: begin
        pt_coord   = px;
        kept_coord = rd_data[COORD_W-1:0];
      end
      S_Y: begin
        pt_coord   = py;
        kept_coord = rd_data[2*COORD_W-1:COORD_W];
      end
      default: begin
        pt_coord   = pz;
        kept_coord = rd_data[3*COORD_W-1:2*COORD_W];
      end
    endcase
  end

  // Absolute difference fits in 24 bits since both ends are 24-bit signed.
  assign diff    = {pt_coord[COORD_W-1], pt_coord} - {kept_coord[COORD_W-1], kept_coord};
  assign mag     = diff[COORD_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  assign mul_op  = (state == S_RAD) ? {1'b0, dup_radius} : mag;
  assign mul_out = SQ_W'(mul_op) * SQ_W'(mul_op);

  // Final distance and compare, and scan index step.
  assign dist_sum = acc + DIST_W'(sq);
  assign near     = dist_sum < DIST_W'(r2);
  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);

  // Decision made when the result is loaded.
  always_comb begin
    verdict_next = VERDICT_KEPT;
    total_after  = total;
    slot_cnt     = '0;
    ram_we       = 1'b0;
    if (dup) begin
      verdict_next = VERDICT_DUP;
    end else if (total >= MAX_CNT) begin
      verdict_next = VERDICT_FULL;
    end else begin
      verdict_next = VERDICT_KEPT;
      total_after  = total + CNT_W'(1);
      slot_cnt     = total;
      ram_we       = load_out;
    end
  end

  assign slot_ext  = {9'd0, slot_cnt};
  assign count_ext = {9'd0, total_after};
  assign ram_re    = (state == S_READ);

  // Point table: x, y and z of one entry side by side.
  rpd_ram #(
    .WIDTH(IN_DATA_W),
    .DEPTH(MAX_KEPT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(total[ADDR_W-1:0]),
    .wdata({pz, py, px}),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rd_data)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      idx   <= '0;
      dup   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px    <= s_tdata[COORD_W-1:0];
            py    <= s_tdata[2*COORD_W-1:COORD_W];
            pz    <= s_tdata[3*COORD_W-1:2*COORD_W];
            idx   <= '0;
            dup   <= 1'b0;
            if (s_tuser) begin
              total <= '0;
            end
            state <= S_RAD;
          end
        end
        S_RAD: begin
          r2    <= mul_out;
          state <= (total == '0) ? S_OUT : S_READ;
        end
        S_READ: begin
          state <= S_X;
        end
        S_X: begin
          sq    <= mul_out;
          state <= S_Y;
        end
        S_Y: begin
          acc   <= DIST_W'(sq);
          sq    <= mul_out;
          state <= S_Z;
        end
        S_Z: begin
          acc   <= acc + DIST_W'(sq);
          sq    <= mul_out;
          state <= S_CMP;
        end
        S_CMP: begin
          if (near) begin
            dup   <= 1'b1;
            state <= S_OUT;
          end else if (idx_inc == total) begin
            state <= S_OUT;
          end else begin
            idx   <= idx_inc[ADDR_W-1:0];
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (out_free) begin
            total <= total_after;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'd0, count_ext[COUNT_W-1:0], slot_ext[SLOT_W-1:0], verdict_next};
    end
  end

`ifndef SYNTHESIS
  // The kept count never passes the table depth.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= MAX_CNT)
    else $error("kept count above table depth");

  // Only entries that were written are ever read.
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (CNT_W'(idx) < total))
    else $error("read of an entry beyond the kept count");

  // A kept verdict grows the table by exactly one.
  a_kept_grows: assert property (@(posedge clk) disable iff (rst)
    (load_out && (verdict_next == VERDICT_KEPT)) |=> (total == $past(total) + CNT_W'(1)))
    else $error("kept point did not grow the table");

  // A result never carries the unused verdict code.
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == VERDICT_KEPT || m_tdata[1:0] == VERDICT_DUP ||
                  m_tdata[1:0] == VERDICT_FULL))
    else $error("result with an unused verdict code");
`endif

endmodule
